>>> hw/rtl/sitda_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the signed integer to
// decimal ASCII unit. No dependencies.
package sitda_pkg;

    localparam int VALUE_W        = 32;
    localparam int NUM_DIGITS     = 10;
    localparam int BITS_PER_STAGE = 8;
    localparam int DABBLE_STAGES  = VALUE_W / BITS_PER_STAGE;
    localparam int CHAR_W         = 6;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

    typedef logic [3:0]                  t_digit;
    typedef logic [NUM_DIGITS-1:0][3:0]  t_bcd;
    typedef logic [3:0]                  t_digit_cnt;
    typedef logic [VALUE_W-1:0]          t_mag;

    // Converted number handed from the conversion pipe to the serializer
    typedef struct packed {
        logic       neg;
        t_bcd       bcd;
        t_digit_cnt ndig;
    } t_conv;

    // One shift-and-add-3 step: add 3 to every nibble of 5 or more, then shift in one bit
    function automatic t_bcd dabble_step(input t_bcd bcd, input logic bit_in);
        t_bcd adj;
        adj = bcd;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd[i] >= 4'd5) begin
                adj[i] = bcd[i] + 4'd3;
            end
        end
        return {adj[NUM_DIGITS-1][2:0], adj[NUM_DIGITS-2:0], bit_in};
    endfunction

    // Digits needed: index of the highest nonzero digit plus one, at least one
    function automatic t_digit_cnt digit_count(input t_bcd bcd);
        t_digit_cnt cnt;
        cnt = 4'd1;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd[i] != 4'd0) begin
                cnt = 4'(i + 1);
            end
        end
        return cnt;
    endfunction

endpackage

>>> hw/rtl/sitda_convert.sv
`timescale 1ns / 1ps
// Conversion pipeline: magnitude, four double-dabble stages of eight bits,
// digit count. Elastic stages with per-stage valid bits. Uses sitda_pkg.
module sitda_convert (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [31:0]               i_value,
    output logic                      o_valid,
    input  logic                      i_ready,
    output sitda_pkg::t_conv          o_conv
);
    import sitda_pkg::*;

    localparam int LAST = DABBLE_STAGES + 1;

    logic r_v   [0:LAST];
    logic r_neg [0:LAST];
    t_bcd r_bcd [0:LAST];
    t_mag r_mag [0:DABBLE_STAGES-1];
    t_digit_cnt r_ndig;

    logic adv [0:LAST];

    always_comb begin
        adv[LAST] = !r_v[LAST] || i_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign o_ready = adv[0];

    // Stage 0: sign and magnitude (most negative value wraps to 2^31 unsigned)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (adv[0]) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0] && i_valid) begin
            r_neg[0] <= i_value[31];
            r_mag[0] <= i_value[31] ? (32'd0 - i_value) : i_value;
            r_bcd[0] <= '0;
        end
    end

    genvar g;
    generate
        for (g = 1; g <= DABBLE_STAGES; g++) begin : g_dabble
            t_bcd n_bcd;

            always_comb begin
                n_bcd = r_bcd[g-1];
                for (int s = 0; s < BITS_PER_STAGE; s++) begin
                    n_bcd = dabble_step(n_bcd, r_mag[g-1][VALUE_W-1-s]);
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[g] <= 1'b0;
                end else if (adv[g]) begin
                    r_v[g] <= r_v[g-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (adv[g] && r_v[g-1]) begin
                    r_neg[g] <= r_neg[g-1];
                    r_bcd[g] <= n_bcd;
                end
            end

            // Remaining magnitude bits only go on to later dabble stages
            if (g < DABBLE_STAGES) begin : g_mag
                always_ff @(posedge i_clk) begin
                    if (adv[g] && r_v[g-1]) begin
                        r_mag[g] <= r_mag[g-1] << BITS_PER_STAGE;
                    end
                end
            end
        end
    endgenerate

    // Last stage: number of significant digits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[LAST] <= 1'b0;
        end else if (adv[LAST]) begin
            r_v[LAST] <= r_v[LAST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[LAST] && r_v[LAST-1]) begin
            r_neg[LAST] <= r_neg[LAST-1];
            r_bcd[LAST] <= r_bcd[LAST-1];
            r_ndig      <= digit_count(r_bcd[LAST-1]);
        end
    end

    assign o_valid     = r_v[LAST];
    assign o_conv.neg  = r_neg[LAST];
    assign o_conv.bcd  = r_bcd[LAST];
    assign o_conv.ndig = r_ndig;

endmodule

>>> hw/rtl/sitda_serializer.sv
`timescale 1ns / 1ps
// Character serializer: emits optional '-' then the digits, most significant
// first, one per output transaction. Uses sitda_pkg.
module sitda_serializer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  sitda_pkg::t_conv          i_conv,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [5:0]                o_text_char,
    output logic                      o_final_char
);
    import sitda_pkg::*;

    logic       r_busy, n_busy;
    logic       r_neg_pend, n_neg_pend;
    t_digit_cnt r_left, n_left;
    t_bcd       r_bcd;

    logic   take_out;
    logic   last_char;
    logic   load;
    t_digit cur_digit;

    assign cur_digit = r_bcd[r_left - 4'd1];
    assign last_char = !r_neg_pend && (r_left == 4'd1);
    assign take_out  = r_busy && i_ready;
    assign o_ready   = !r_busy || (take_out && last_char);
    assign load      = i_valid && o_ready;

    always_comb begin
        n_busy     = r_busy;
        n_neg_pend = r_neg_pend;
        n_left     = r_left;
        if (load) begin
            n_busy     = 1'b1;
            n_neg_pend = i_conv.neg;
            n_left     = i_conv.ndig;
        end else if (take_out) begin
            if (last_char) begin
                n_busy = 1'b0;
            end else if (r_neg_pend) begin
                n_neg_pend = 1'b0;
            end else begin
                n_left = r_left - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_neg_pend <= 1'b0;
            r_left     <= 4'd1;
        end else begin
            r_busy     <= n_busy;
            r_neg_pend <= n_neg_pend;
            r_left     <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bcd <= i_conv.bcd;
        end
    end

    assign o_valid      = r_busy;
    assign o_text_char  = r_neg_pend ? CHAR_MINUS : (CHAR_ZERO + {2'b00, cur_digit});
    assign o_final_char = last_char;

endmodule

>>> hw/rtl/signed_int_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps
// Signed 32-bit integer to decimal ASCII text, one character per transaction.
// First character: the input passes the 6 pipe stages of the converter, then the serializer register.
// Throughput: one character per cycle while i_ready is high; a number is 1 to 11
// characters long; the conversion pipe accepts every cycle unless backed up from the output.
// Reset: synchronous active-low i_rst_n clears all valid and busy flags.
module signed_int_to_decimal_ascii_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_text_char,
    output logic        o_final_char
);
    import sitda_pkg::*;

    t_conv conv;
    logic  conv_valid;
    logic  conv_ready;

    sitda_convert u_convert (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_value (i_value),
        .o_valid (conv_valid),
        .i_ready (conv_ready),
        .o_conv  (conv)
    );

    sitda_serializer u_serializer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (conv_valid),
        .o_ready      (conv_ready),
        .i_conv       (conv),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_text_char  (o_text_char),
        .o_final_char (o_final_char)
    );

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for signed_int_to_decimal_ascii_unit: converts each
// transaction's value to its expected character stream and checks it in order.
// Depends on sitda_pkg and the unit's RTL.
module testbench;
    import sitda_pkg::*;

    localparam int IDLE_LIMIT   = 4000;  // cycles with no transaction on either side
    localparam int MAX_REPORTED = 10;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              fin;
    } t_text_char;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [31:0] i_value = '0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [5:0]  o_text_char;
    logic        o_final_char;

    t_text_char expected_chars[$];
    int err_count     = 0;
    int idle_cycles   = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int holdoff_req   = 0;
    int holdoff_left  = 0;

    signed_int_to_decimal_ascii_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_text_char  (o_text_char),
        .o_final_char (o_final_char)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Decimal text of a two's complement word, most significant character first
    function automatic void predict_text(input logic [31:0] v);
        logic [31:0] mag;
        logic [3:0]  digs[10];
        int          nd;
        t_text_char  c;
        nd  = 0;
        mag = v[31] ? (32'd0 - v) : v;
        do begin
            digs[nd] = 4'(mag % 32'd10);
            mag = mag / 32'd10;
            nd++;
        end while (mag != 0 && nd < 10);
        if (v[31]) begin
            c.ch  = CHAR_MINUS;
            c.fin = 1'b0;
            expected_chars.push_back(c);
        end
        for (int i = nd - 1; i >= 0; i--) begin
            c.ch  = CHAR_ZERO + CHAR_W'(digs[i]);
            c.fin = (i == 0);
            expected_chars.push_back(c);
        end
    endfunction

    task automatic note_error(input string what, input t_text_char want);
        err_count++;
        if (err_count <= MAX_REPORTED) begin
            $display("%0t: %s: expected char %0d final %0b, got char %0d final %0b",
                     $realtime, what, want.ch, want.fin, o_text_char, o_final_char);
        end
    endtask

    // Output checker runs first so a same-edge input transaction cannot affect it
    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_chars.size() == 0) begin
                    want = '0;
                    note_error("character with nothing pending", want);
                end else begin
                    want = expected_chars.pop_front();
                    if (o_text_char !== want.ch || o_final_char !== want.fin) begin
                        note_error("character mismatch", want);
                    end
                end
            end
            if (i_valid && o_ready) begin
                predict_text(i_value);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_ready <= 1'b0;
        end else if (holdoff_req > 0) begin
            holdoff_left = holdoff_req - 1;
            holdoff_req  = 0;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction
    task automatic send_value(input logic [31:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            i_value <= $urandom;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Mix of digit lengths so short and long texts both show up often
    function automatic logic [31:0] rand_value();
        logic [31:0] lim;
        logic [31:0] mag;
        int          nd;
        if ($urandom_range(3) == 0) begin
            return $urandom;
        end
        nd  = $urandom_range(1, 9);
        lim = 32'd1;
        for (int i = 0; i < nd; i++) lim = lim * 32'd10;
        mag = $urandom % lim;
        return $urandom_range(1) ? (32'd0 - mag) : mag;
    endfunction

    task automatic test_directed_values();
        logic [31:0] vals[$];
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        vals = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                 32'd999999999, -32'sd999999999, 32'd1234567890, -32'sd1000000000,
                 32'hAAAA_AAAA, 32'h5555_5555};
        foreach (vals[i]) send_value(vals[i]);
    endtask

    task automatic run_random(input int count, input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) send_value(rand_value());
    endtask

    task automatic test_no_idling();
        run_random(30, 0, 0);
    endtask

    task automatic test_sender_gaps();
        run_random(30, 46, 0);
    endtask

    task automatic test_receiver_stalls();
        run_random(30, 0, 46);
    endtask

    task automatic test_both_idling();
        run_random(30, 35, 35);
    endtask

    // Long output hold-off with the sender pushing eleven-character texts
    task automatic test_output_holdoff();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_req    = 300;
        repeat (20) send_value(32'h8000_0000 | ($urandom % 32'd147483648));
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_values();
        test_no_idling();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idling();
        test_output_holdoff();
        i_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> signed_int_to_decimal_ascii_unit.f
hw/rtl/sitda_pkg.sv
hw/rtl/sitda_convert.sv
hw/rtl/sitda_serializer.sv
hw/rtl/signed_int_to_decimal_ascii_unit.sv
bench/testbench.sv
